>>> hdl/gss_pkg.sv
// Shared constants, types and tables of the grid skewness stencil.
`timescale 1ns / 1ps
package gss_pkg;

  localparam int MAX_POINTS = 256;
  localparam int COORD_W    = 32;
  localparam int COL_W      = $clog2(MAX_POINTS);
  localparam int SLOT_W     = 2;
  localparam int ROWS_KEPT  = 3;
  localparam int RAM_DEPTH  = ROWS_KEPT * MAX_POINTS;
  localparam int ADDR_W     = SLOT_W + COL_W;
  localparam int PT_W       = 2 * COORD_W;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int NORM_TOP   = 29;
  localparam int XY_W       = NORM_TOP + 5;
  localparam int Z_W        = 24;
  localparam int SKEW_W     = 14;
  localparam int SIZE_W     = 9;
  localparam int ITER_W     = 4;

  localparam logic [SIZE_W-1:0] GRID_RESET = SIZE_W'(256);
  localparam logic [SIZE_W-1:0] GRID_MIN   = SIZE_W'(3);
  localparam logic [SIZE_W-1:0] GRID_MAX   = SIZE_W'(MAX_POINTS);
  localparam logic [SKEW_W-1:0] SKEW_MAX   = SKEW_W'(9000);

  // How a result's skew and flag are formed.
  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_DEGEN,
    KIND_ANGLE
  } gss_kind_t;

  typedef struct packed {
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_addr;
    logic                  load_a;
    logic                  load_p;
    logic                  load_s;
    logic                  mul_en;
    logic [1:0]            mul_sel;
    logic                  acc_en;
    logic [1:0]            acc_sel;
    logic                  norm_load;
    logic                  norm_en;
    logic                  cordic_init;
    logic                  cordic_en;
    logic [ITER_W-1:0]     cordic_i;
    logic                  out_load;
    gss_kind_t             out_kind;
    logic [COL_W-1:0]      out_row;
    logic [COL_W-1:0]      out_col;
    logic                  out_last;
  } gss_cmd_t;

  typedef struct packed {
    logic degen;
    logic norm_done;
  } gss_sts_t;

  // atan(2^-i) in centidegrees, scaled by 256.
  function automatic logic [Z_W-1:0] atan_step(input logic [ITER_W-1:0] i);
    logic [Z_W-1:0] v;
    unique case (i)
      4'd0:    v = Z_W'(1152000);
      4'd1:    v = Z_W'(680065);
      4'd2:    v = Z_W'(359328);
      4'd3:    v = Z_W'(182400);
      4'd4:    v = Z_W'(91554);
      4'd5:    v = Z_W'(45822);
      4'd6:    v = Z_W'(22916);
      4'd7:    v = Z_W'(11459);
      4'd8:    v = Z_W'(5730);
      4'd9:    v = Z_W'(2865);
      4'd10:   v = Z_W'(1432);
      4'd11:   v = Z_W'(716);
      4'd12:   v = Z_W'(358);
      4'd13:   v = Z_W'(179);
      4'd14:   v = Z_W'(90);
      default: v = Z_W'(45);
    endcase
    return v;
  endfunction

endpackage

>>> hdl/gss_ifs.sv
// Handshake interfaces for the point, result and configuration channels.
`timescale 1ns / 1ps
interface gss_pt_if;
  logic        valid;
  logic        ready;
  logic [31:0] x_coord;
  logic [31:0] y_coord;
  modport source (output valid, x_coord, y_coord, input ready);
  modport sink (input valid, x_coord, y_coord, output ready);
endinterface

interface gss_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  row;
  logic [7:0]  col;
  logic [13:0] skew_centideg;
  logic        degenerate;
  logic        last;
  modport source (output valid, row, col, skew_centideg, degenerate, last, input ready);
  modport sink (input valid, row, col, skew_centideg, degenerate, last, output ready);
endinterface

interface gss_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> hdl/gss_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module gss_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> hdl/gss_datapath.sv
// Datapath: tangent differences, dot and cross products, normalizer, CORDIC, result register.
`timescale 1ns / 1ps
module gss_datapath import gss_pkg::*; (
  input  logic                  clk,
  input  gss_cmd_t              cmd,
  input  logic [PT_W-1:0]       rd_data,
  output gss_sts_t              sts,
  output logic [COL_W-1:0]      row,
  output logic [COL_W-1:0]      col,
  output logic [SKEW_W-1:0]     skew_centideg,
  output logic                  degenerate,
  output logic                  last
);
  logic signed [COORD_W-1:0] ax, ay, rx, ry;
  logic signed [DIFF_W-1:0]  xp, yp, xs, ys, op_a, op_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   prod_ext, dot, crs;
  logic [ACC_W-1:0]          na, nb, nm;
  logic signed [XY_W-1:0]    cx, cy, dx, dy;
  logic signed [Z_W-1:0]     cz, zr;
  logic [SKEW_W-1:0]         angle;

  assign rx = signed'(rd_data[PT_W-1:COORD_W]);
  assign ry = signed'(rd_data[COORD_W-1:0]);

  // Operand choice: 0 xp*xs, 1 yp*ys, 2 xp*ys, 3 yp*xs.
  assign op_a = cmd.mul_sel[0] ? yp : xp;
  assign op_b = (cmd.mul_sel == 2'd1 || cmd.mul_sel == 2'd2) ? ys : xs;
  assign prod_ext = ACC_W'(prod);

  assign nm = na | nb;
  assign sts.norm_done = nm[NORM_TOP] && !(|nm[ACC_W-1:NORM_TOP+1]);
  assign sts.degen = (xp == '0 && yp == '0) || (xs == '0 && ys == '0);

  assign dx = cy >>> cmd.cordic_i;
  assign dy = cx >>> cmd.cordic_i;

  // Round to centidegrees and clamp between zero and the right angle.
  assign zr = cz + Z_W'(128);
  always_comb begin
    if (cz[Z_W-1]) begin
      angle = '0;
    end else if (zr[Z_W-1:8] > (Z_W-8)'(SKEW_MAX)) begin
      angle = SKEW_MAX;
    end else begin
      angle = SKEW_W'(zr[Z_W-1:8]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_a) begin
      ax <= rx;
      ay <= ry;
    end
    if (cmd.load_p) begin
      xp <= DIFF_W'(ax) - DIFF_W'(rx);
      yp <= DIFF_W'(ay) - DIFF_W'(ry);
    end
    if (cmd.load_s) begin
      xs <= DIFF_W'(ax) - DIFF_W'(rx);
      ys <= DIFF_W'(ay) - DIFF_W'(ry);
    end
    if (cmd.mul_en) begin
      prod <= op_a * op_b;
    end
    if (cmd.acc_en) begin
      unique case (cmd.acc_sel)
        2'd0:    dot <= prod_ext;
        2'd1:    dot <= dot + prod_ext;
        2'd2:    crs <= prod_ext;
        default: crs <= crs - prod_ext;
      endcase
    end
    if (cmd.norm_load) begin
      na <= dot[ACC_W-1] ? ACC_W'(-dot) : ACC_W'(dot);
      nb <= crs[ACC_W-1] ? ACC_W'(-crs) : ACC_W'(crs);
    end else if (cmd.norm_en) begin
      if (|nm[ACC_W-1:NORM_TOP+1]) begin
        na <= na >> 1;
        nb <= nb >> 1;
      end else begin
        na <= na << 1;
        nb <= nb << 1;
      end
    end
    if (cmd.cordic_init) begin
      cx <= XY_W'(nb[NORM_TOP:0]);
      cy <= XY_W'(na[NORM_TOP:0]);
      cz <= '0;
    end else if (cmd.cordic_en) begin
      if (!cy[XY_W-1]) begin
        cx <= cx + dx;
        cy <= cy - dy;
        cz <= cz + signed'(atan_step(cmd.cordic_i));
      end else begin
        cx <= cx - dx;
        cy <= cy + dy;
        cz <= cz - signed'(atan_step(cmd.cordic_i));
      end
    end
    if (cmd.out_load) begin
      row  <= cmd.out_row;
      col  <= cmd.out_col;
      last <= cmd.out_last;
      unique case (cmd.out_kind)
        KIND_ANGLE: begin
          skew_centideg <= angle;
          degenerate    <= 1'b0;
        end
        KIND_DEGEN: begin
          skew_centideg <= '0;
          degenerate    <= 1'b1;
        end
        default: begin
          skew_centideg <= '0;
          degenerate    <= 1'b0;
        end
      endcase
    end
  end
endmodule

>>> hdl/gss_ctrl.sv
// Controller: grid counters, result scheduling and the per-result sequence.
`timescale 1ns / 1ps
module gss_ctrl import gss_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cfg_valid,
  input  logic [SIZE_W-1:0]  cfg_data,
  output logic               cfg_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  gss_sts_t           sts,
  output gss_cmd_t           cmd
);
  typedef enum logic [3:0] {
    ST_IDLE, ST_SEL, ST_JOB, ST_RA, ST_RB, ST_RC, ST_RD, ST_DF,
    ST_CHK, ST_MUL, ST_NLD, ST_NRM, ST_CRD, ST_FIN, ST_OUT
  } state_t;

  state_t              state;
  logic [SIZE_W-1:0]   g_reg, ge, ge_m1, r9, c9, c_inc, r_inc;
  logic [COL_W-1:0]    row_cnt, col_cnt, r_eff, c_eff, in_r, in_c;
  logic [COL_W-1:0]    job_row, job_col;
  logic [SLOT_W-1:0]   slot_cnt, slot_eff, s_cur, s_prv, s_pv2;
  logic [SLOT_W-1:0]   job_rs, job_pa, job_pb;
  logic [2:0]          jobs, job_bit;
  logic [ITER_W-1:0]   cnt;
  logic                wrap, accept, job_edge;

  assign ge    = (g_reg < GRID_MIN) ? GRID_MIN : ((g_reg > GRID_MAX) ? GRID_MAX : g_reg);
  assign ge_m1 = ge - SIZE_W'(1);
  assign wrap  = ({1'b0, row_cnt} >= ge) || ({1'b0, col_cnt} >= ge);
  assign r_eff = wrap ? '0 : row_cnt;
  assign c_eff = wrap ? '0 : col_cnt;
  assign slot_eff = wrap ? '0 : slot_cnt;
  assign r9    = {1'b0, r_eff};
  assign c9    = {1'b0, c_eff};
  assign c_inc = c9 + SIZE_W'(1);
  assign r_inc = r9 + SIZE_W'(1);

  assign cfg_ready = (state == ST_IDLE);
  assign in_ready  = (state == ST_IDLE) && !cfg_valid;
  assign accept    = in_valid && in_ready;
  assign out_valid = (state == ST_OUT);
  assign job_edge  = (job_col == '0) || ({1'b0, job_col} >= ge_m1);

  always_comb begin
    cmd          = '0;
    cmd.out_row  = job_row;
    cmd.out_col  = job_col;
    cmd.out_last = ((jobs & ~job_bit) == 3'b000);
    cmd.cordic_i = cnt;
    cmd.out_kind = KIND_ZERO;
    unique case (state)
      ST_IDLE: begin
        cmd.ram_we   = accept;
        cmd.ram_addr = {slot_eff, c_eff};
      end
      ST_JOB: begin
        cmd.out_load = job_edge;
      end
      ST_RA: cmd.ram_addr = {job_rs, job_col + COL_W'(1)};
      ST_RB: begin
        cmd.ram_addr = {job_rs, job_col - COL_W'(1)};
        cmd.load_a   = 1'b1;
      end
      ST_RC: begin
        cmd.ram_addr = {job_pa, job_col};
        cmd.load_p   = 1'b1;
      end
      ST_RD: begin
        cmd.ram_addr = {job_pb, job_col};
        cmd.load_a   = 1'b1;
      end
      ST_DF: cmd.load_s = 1'b1;
      ST_CHK: begin
        cmd.out_load = sts.degen;
        cmd.out_kind = KIND_DEGEN;
      end
      ST_MUL: begin
        cmd.mul_en  = (cnt < ITER_W'(4));
        cmd.mul_sel = cnt[1:0];
        cmd.acc_en  = (cnt != '0);
        cmd.acc_sel = 2'(cnt - ITER_W'(1));
      end
      ST_NLD: cmd.norm_load = 1'b1;
      ST_NRM: begin
        cmd.norm_en     = !sts.norm_done;
        cmd.cordic_init = sts.norm_done;
      end
      ST_CRD: cmd.cordic_en = 1'b1;
      ST_FIN: begin
        cmd.out_load = 1'b1;
        cmd.out_kind = KIND_ANGLE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      g_reg    <= GRID_RESET;
      row_cnt  <= '0;
      col_cnt  <= '0;
      slot_cnt <= '0;
      jobs     <= '0;
      job_bit  <= '0;
      cnt      <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cfg_valid) begin
            g_reg    <= cfg_data;
            row_cnt  <= '0;
            col_cnt  <= '0;
            slot_cnt <= '0;
          end else if (accept) begin
            in_r  <= r_eff;
            in_c  <= c_eff;
            s_cur <= slot_eff;
            s_prv <= (slot_eff == 2'd0) ? 2'd2 : slot_eff - 2'd1;
            s_pv2 <= (slot_eff == 2'd0) ? 2'd1 : ((slot_eff == 2'd1) ? 2'd2 : 2'd0);
            jobs  <= {(r9 == ge_m1) && (c9 == ge_m1),
                      (r9 == ge_m1) && (c_eff != '0),
                      (r_eff != '0)};
            if (c_inc >= ge) begin
              col_cnt <= '0;
              if (r_inc >= ge) begin
                row_cnt  <= '0;
                slot_cnt <= '0;
              end else begin
                row_cnt  <= r_inc[COL_W-1:0];
                slot_cnt <= (slot_eff == 2'd2) ? 2'd0 : slot_eff + 2'd1;
              end
            end else begin
              row_cnt  <= r_eff;
              col_cnt  <= c_inc[COL_W-1:0];
              slot_cnt <= slot_eff;
            end
            state <= ST_SEL;
          end
        end
        ST_SEL: begin
          priority if (jobs[0]) begin
            job_bit <= 3'b001;
            job_row <= in_r - COL_W'(1);
            job_col <= in_c;
            job_rs  <= s_prv;
            job_pa  <= s_cur;
            job_pb  <= (in_r == COL_W'(1)) ? s_prv : s_pv2;
            state   <= ST_JOB;
          end else if (jobs[1]) begin
            job_bit <= 3'b010;
            job_row <= in_r;
            job_col <= in_c - COL_W'(1);
            job_rs  <= s_cur;
            job_pa  <= s_cur;
            job_pb  <= s_prv;
            state   <= ST_JOB;
          end else if (jobs[2]) begin
            job_bit <= 3'b100;
            job_row <= in_r;
            job_col <= in_c;
            state   <= ST_JOB;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_JOB: state <= job_edge ? ST_OUT : ST_RA;
        ST_RA:  state <= ST_RB;
        ST_RB:  state <= ST_RC;
        ST_RC:  state <= ST_RD;
        ST_RD:  state <= ST_DF;
        ST_DF:  state <= ST_CHK;
        ST_CHK: begin
          cnt   <= '0;
          state <= sts.degen ? ST_OUT : ST_MUL;
        end
        ST_MUL: begin
          cnt <= cnt + ITER_W'(1);
          if (cnt == ITER_W'(4)) begin
            state <= ST_NLD;
          end
        end
        ST_NLD: state <= ST_NRM;
        ST_NRM: begin
          if (sts.norm_done) begin
            cnt   <= '0;
            state <= ST_CRD;
          end
        end
        ST_CRD: begin
          cnt <= cnt + ITER_W'(1);
          if (cnt == '1) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: state <= ST_OUT;
        ST_OUT: begin
          if (out_ready) begin
            jobs  <= jobs & ~job_bit;
            state <= ((jobs & ~job_bit) == 3'b000) ? ST_IDLE : ST_SEL;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

>>> hdl/grid_skewness_stencil_unit.sv
// Top level of the grid skewness stencil: channels, line store, controller and datapath.
`timescale 1ns / 1ps
// The unit takes the points of a G by G structured grid in row-major order, one
// point per beat on pts, and returns on res the skewness of each point in hundredths
// of a degree, with its row and column. The three most recent rows sit in a
// 768-entry line store (one single-port RAM), so the result for a point of row r-1
// comes out while row r is streaming in; the last row's results follow its own
// points, and the last point of a grid also releases its own result. An input
// beat therefore causes zero to three result beats, and last marks the final one.
// Points are handled one at a time: a point is taken, then each result it causes
// runs through the sequencer. A result on the left or right column skips the
// arithmetic and carries zero skew. An interior result runs through line-store reads
// (one RAM port), the dot and cross products on the shared multiplier, one cycle
// per bit of normalizing shift (up to 35) and sixteen CORDIC iterations, and then
// waits out any stall on res.
// The next point is taken only once every result of the previous one has been
// delivered. A write on cfg sets the grid size (clamped to 3..256) and restarts
// the grid at row 0, column 0; it is taken only while the unit is idle. The line
// store has no reset: entries are always written before they are read.
module grid_skewness_stencil_unit import gss_pkg::*; (
  input logic      clk,
  input logic      rst,
  gss_pt_if.sink   pts,
  gss_res_if.source res,
  gss_cfg_if.sink  cfg
);
  gss_cmd_t        cmd;
  gss_sts_t        sts;
  logic [PT_W-1:0] rd_data;

  // Sequencer: owns the grid counters and walks each result through the datapath.
  gss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pts.valid),
    .in_ready  (pts.ready),
    .cfg_valid (cfg.valid),
    .cfg_data  (cfg.data),
    .cfg_ready (cfg.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Line store: slot (row mod 3) times 256, plus the column.
  gss_ram #(
    .WIDTH (PT_W),
    .DEPTH (RAM_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (cmd.ram_we),
    .addr  (cmd.ram_addr),
    .wdata ({pts.x_coord, pts.y_coord}),
    .rdata (rd_data)
  );

  // Arithmetic and the result register that drives the res payload.
  gss_datapath u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .rd_data       (rd_data),
    .sts           (sts),
    .row           (res.row),
    .col           (res.col),
    .skew_centideg (res.skew_centideg),
    .degenerate    (res.degenerate),
    .last          (res.last)
  );

  // While a result waits, no new point may enter.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !pts.ready)
    else $error("point accepted while a result is pending");

  // A point beat is always followed by work before the unit is ready again.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (pts.valid && pts.ready) |=> !pts.ready)
    else $error("unit ready right after taking a point");

  // Skew never exceeds a right angle.
  a_skew_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.skew_centideg <= SKEW_MAX))
    else $error("skew out of range");

  // A degenerate result carries zero skew.
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.degenerate) |-> (res.skew_centideg == '0))
    else $error("degenerate result with nonzero skew");
endmodule
